>>> hdl/ufml_pkg.sv
// Package for the union-find engine with member lists.
// Holds sizes, the controller command codes and the status bundle.
// No dependencies.
package ufml_pkg;
	localparam int NODES = 1024;
	localparam int LBL_W = 10;
	localparam int CNT_W = 11;

	typedef logic [LBL_W-1:0] lbl_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_LA,
		CMD_LB,
		CMD_CA,
		CMD_CB,
		CMD_QC,
		CMD_WRD,
		CMD_WCHK,
		CMD_TW,
		CMD_TL,
		CMD_FIN
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic same;
		logic walk_end;
		logic clr_last;
	} stat_t;
endpackage

>>> hdl/ufml_datapath.sv
// Datapath of the union-find engine: label, next, tail and count memories,
// the working registers and the result registers.
// Depends on ufml_pkg.
module ufml_datapath import ufml_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	input  logic         action,
	input  logic [9:0]   node_a,
	input  logic [9:0]   node_b,
	output stat_t        stat,
	output logic         done,
	output logic [9:0]   label_out,
	output logic [10:0]  size_out,
	output logic [10:0]  count_out,
	output logic         merged
);
	lbl_t label_mem [NODES];
	lbl_t next_mem  [NODES];
	lbl_t tail_mem  [NODES];
	cnt_t count_mem [NODES];

	lbl_t lbl_rd_q, nxt_rd_q, tl_rd_q;
	cnt_t cnt_rd_q;
	lbl_t clr_q, a_q, b_q, la_q, lb_q, w_q, l_q, n_q;
	cnt_t ca_q, sum_q, total_q;
	logic act_q;

	lbl_t lbl_ra, nxt_ra, tl_ra, cnt_ra;
	lbl_t lbl_wa, lbl_wd, nxt_wa, nxt_wd, tl_wa, tl_wd, cnt_wa;
	cnt_t cnt_wd;
	logic lbl_we, nxt_we, tl_we, cnt_we;

	always_comb begin
		lbl_ra = a_q;
		nxt_ra = n_q;
		tl_ra  = w_q;
		cnt_ra = la_q;
		lbl_we = 1'b0; nxt_we = 1'b0; tl_we = 1'b0; cnt_we = 1'b0;
		lbl_wa = clr_q; lbl_wd = clr_q;
		nxt_wa = clr_q; nxt_wd = clr_q;
		tl_wa  = clr_q; tl_wd  = clr_q;
		cnt_wa = clr_q; cnt_wd = cnt_t'(1);
		case (cmd)
			CMD_CLEAR: begin
				lbl_we = 1'b1; nxt_we = 1'b1; tl_we = 1'b1; cnt_we = 1'b1;
			end
			CMD_LOAD: lbl_ra = node_a;
			CMD_LA: begin
				lbl_ra = b_q;
				cnt_ra = lbl_rd_q;
			end
			CMD_LB: cnt_ra = la_q;
			CMD_CA: cnt_ra = lb_q;
			CMD_WRD: begin
				nxt_ra = n_q;
				lbl_we = 1'b1; lbl_wa = n_q; lbl_wd = w_q;
			end
			CMD_WCHK: tl_ra = w_q;
			CMD_TW: begin
				nxt_we = 1'b1; nxt_wa = tl_rd_q; nxt_wd = l_q;
				tl_ra = l_q;
			end
			CMD_TL: begin
				tl_we = 1'b1; tl_wa = w_q; tl_wd = tl_rd_q;
				cnt_we = 1'b1; cnt_wa = w_q; cnt_wd = sum_q;
			end
			CMD_FIN: begin
				cnt_we = 1'b1; cnt_wa = l_q; cnt_wd = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (lbl_we) label_mem[lbl_wa] <= lbl_wd;
		lbl_rd_q <= label_mem[lbl_ra];
		if (nxt_we) next_mem[nxt_wa] <= nxt_wd;
		nxt_rd_q <= next_mem[nxt_ra];
		if (tl_we) tail_mem[tl_wa] <= tl_wd;
		tl_rd_q <= tail_mem[tl_ra];
		if (cnt_we) count_mem[cnt_wa] <= cnt_wd;
		cnt_rd_q <= count_mem[cnt_ra];
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				a_q <= node_a; b_q <= node_b; act_q <= action;
			end
			CMD_LA: la_q <= lbl_rd_q;
			CMD_LB: lb_q <= lbl_rd_q;
			CMD_CA: ca_q <= cnt_rd_q;
			CMD_CB: begin
				sum_q <= cnt_rd_q + ca_q;
				if (ca_q < cnt_rd_q) begin
					w_q <= lb_q; l_q <= la_q; n_q <= la_q;
				end else begin
					w_q <= la_q; l_q <= lb_q; n_q <= lb_q;
				end
			end
			CMD_WCHK: n_q <= nxt_rd_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			total_q <= cnt_t'(NODES);
			done <= 1'b0;
			merged <= 1'b0;
		end else begin
			done <= 1'b0;
			merged <= 1'b0;
			if (cmd == CMD_CLEAR) clr_q <= clr_q + 1'b1;
			if (cmd == CMD_FIN) total_q <= total_q - 1'b1;
			if (cmd == CMD_QC) begin
				done <= 1'b1;
			end else if (cmd == CMD_CB && la_q == lb_q) begin
				done <= 1'b1;
			end else if (cmd == CMD_FIN) begin
				done <= 1'b1;
				merged <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_QC: begin
				label_out <= la_q; size_out <= cnt_rd_q; count_out <= total_q;
			end
			CMD_CB: begin
				label_out <= la_q; size_out <= ca_q; count_out <= total_q;
			end
			CMD_FIN: begin
				label_out <= w_q; size_out <= sum_q; count_out <= total_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign stat.is_query = act_q;
	assign stat.same     = (la_q == lb_q);
	assign stat.walk_end = (nxt_rd_q == n_q);
	assign stat.clr_last = (clr_q == lbl_t'(NODES - 1));
endmodule

>>> hdl/ufml_ctrl.sv
// Controller state machine of the union-find engine.
// Depends on ufml_pkg; drives commands to ufml_datapath.
module ufml_ctrl import ufml_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output logic  busy,
	output cmd_t  cmd
);
	typedef enum logic [11:0] {
		S_CLEAR = 12'b000000000001,
		S_IDLE  = 12'b000000000010,
		S_LA    = 12'b000000000100,
		S_LB    = 12'b000000001000,
		S_CA    = 12'b000000010000,
		S_CB    = 12'b000000100000,
		S_QC    = 12'b000001000000,
		S_WRD   = 12'b000010000000,
		S_WCHK  = 12'b000100000000,
		S_TW    = 12'b001000000000,
		S_TL    = 12'b010000000000,
		S_FIN   = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = CMD_NOP;
		case (state_q)
			S_CLEAR: begin
				cmd = CMD_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd = CMD_LOAD;
					state_d = S_LA;
				end
			end
			S_LA: begin
				cmd = CMD_LA;
				state_d = stat.is_query ? S_QC : S_LB;
			end
			S_QC: begin
				cmd = CMD_QC;
				state_d = S_IDLE;
			end
			S_LB: begin
				cmd = CMD_LB;
				state_d = S_CA;
			end
			S_CA: begin
				cmd = CMD_CA;
				state_d = S_CB;
			end
			S_CB: begin
				cmd = CMD_CB;
				state_d = stat.same ? S_IDLE : S_WRD;
			end
			S_WRD: begin
				cmd = CMD_WRD;
				state_d = S_WCHK;
			end
			S_WCHK: begin
				cmd = CMD_WCHK;
				state_d = stat.walk_end ? S_TW : S_WRD;
			end
			S_TW: begin
				cmd = CMD_TW;
				state_d = S_TL;
			end
			S_TL: begin
				cmd = CMD_TL;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd = CMD_FIN;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);
endmodule

>>> hdl/union_find_member_lists_top.sv
// Top level of the union-find engine with explicit member lists.
// Instantiates ufml_ctrl and ufml_datapath; depends on ufml_pkg.
//
// Channel   Handshake            Payload
// input     start & !busy        action, node_a, node_b
// result    done (one cycle)     label_out, size_out, count_out, merged
//
// A merging union walks the member list of the smaller cluster (on a size tie, the cluster
// of node_b), whose member count M is at most NODES/2: the relabel walk does one
// next-pointer memory read per member, in states S_WRD and S_WCHK.
// After reset the memories are initialized while busy is high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module union_find_member_lists_top import ufml_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic         action,
	input  logic [9:0]   node_a,
	input  logic [9:0]   node_b,
	output logic         done,
	output logic [9:0]   label_out,
	output logic [10:0]  size_out,
	output logic [10:0]  count_out,
	output logic         merged
);
	cmd_t  cmd;
	stat_t stat;

	ufml_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .busy(busy), .cmd(cmd)
	);

	ufml_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .action(action), .node_a(node_a),
		.node_b(node_b), .stat(stat), .done(done), .label_out(label_out),
		.size_out(size_out), .count_out(count_out), .merged(merged)
	);
endmodule

>>> hdl/ufml_checker.sv
// Port-level checker for the union-find engine, bound to the top level.
// Depends on union_find_member_lists_top.
module ufml_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         start,
	input logic         busy,
	input logic         done,
	input logic [10:0]  size_out,
	input logic [10:0]  count_out,
	input logic         merged
);
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy low after transfer");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back result strobes");
	a_merged_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		merged |-> done && size_out >= 11'd2) else $error("bad merged flag");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> count_out != 11'd0) else $error("cluster count zero");
endmodule

bind union_find_member_lists_top ufml_checker u_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.size_out(size_out), .count_out(count_out), .merged(merged)
);

>>> verif/tb_union_find_member_lists_top.sv
// Self-checking testbench for the union-find engine with member lists.
// Drives union and query commands, predicts every result with a local model
// of labels and member lists, and depends on ufml_pkg and the top level RTL.
`timescale 1ns / 100ps

module tb_union_find_member_lists_top;
	import ufml_pkg::*;

	localparam logic ACT_UNION = 1'b0;
	localparam logic ACT_QUERY = 1'b1;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [9:0] label;
		logic [10:0] size;
		logic [10:0] count;
		logic merged;
	} cluster_report_t;

	typedef struct {
		logic act;
		logic [9:0] a;
		logic [9:0] b;
		logic typed;
		cluster_report_t rep;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic action;
	logic [9:0] node_a;
	logic [9:0] node_b;
	logic done;
	logic [9:0] label_out;
	logic [10:0] size_out;
	logic [10:0] count_out;
	logic merged;

	int unsigned node_label [NODES];
	int unsigned node_next [NODES];
	int unsigned label_tail [NODES];
	int unsigned label_size [NODES];
	int unsigned live_clusters;

	cluster_report_t pending_reports [$];
	stim_row_t directed_rows [$];
	int fail_count;
	int idle_cycles;
	int send_gap_pct;

	union_find_member_lists_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .node_a(node_a), .node_b(node_b),
		.done(done), .label_out(label_out), .size_out(size_out),
		.count_out(count_out), .merged(merged)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_clusters();
		for (int i = 0; i < NODES; i++) begin
			node_label[i] = i;
			node_next[i] = i;
			label_tail[i] = i;
			label_size[i] = 1;
		end
		live_clusters = NODES;
	endfunction

	function automatic void relabel_cluster(int unsigned keeper, int unsigned absorbed);
		int unsigned n;
		n = absorbed;
		for (int s = 0; s < NODES; s++) begin
			node_label[n] = keeper;
			if (node_next[n] == n)
				break;
			n = node_next[n];
		end
		node_next[label_tail[keeper]] = absorbed;
		label_tail[keeper] = label_tail[absorbed];
		label_size[keeper] += label_size[absorbed];
		label_size[absorbed] = 0;
		if (live_clusters > 0)
			live_clusters--;
	endfunction

	function automatic cluster_report_t apply_cluster_op(logic act, logic [9:0] a,
			logic [9:0] b);
		cluster_report_t r;
		int unsigned la;
		int unsigned lb;
		r.merged = 1'b0;
		if (act == ACT_UNION && a < NODES && b < NODES) begin
			la = node_label[a];
			lb = node_label[b];
			if (la != lb) begin
				if (label_size[la] < label_size[lb])
					relabel_cluster(lb, la);
				else
					relabel_cluster(la, lb);
				r.merged = 1'b1;
			end
		end
		if (a < NODES) begin
			r.label = node_label[a][9:0];
			r.size = label_size[node_label[a]][10:0];
		end else begin
			r.label = '0;
			r.size = '0;
		end
		r.count = live_clusters[10:0];
		return r;
	endfunction

	task automatic send_item(logic act, logic [9:0] a, logic [9:0] b, logic typed,
			cluster_report_t typed_rep);
		cluster_report_t r;
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			action <= 1'($urandom_range(1));
			node_a <= 10'($urandom);
			node_b <= 10'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		node_a <= a;
		node_b <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		r = apply_cluster_op(act, a, b);
		if (typed && r != typed_rep) begin
			$error("directed row disagrees with prediction for node %0d", a);
			fail_count++;
		end
		pending_reports = {pending_reports, r};
	endtask

	always @(posedge clk) begin
		cluster_report_t e;
		if (arst_n && done) begin
			if (pending_reports.size() == 0) begin
				$error("result with no transfer outstanding");
				fail_count++;
			end else begin
				e = pending_reports.pop_front();
				if (label_out !== e.label) begin
					$error("label_out expected %0d actual %0d", e.label, label_out);
					fail_count++;
				end
				if (size_out !== e.size) begin
					$error("size_out expected %0d actual %0d", e.size, size_out);
					fail_count++;
				end
				if (count_out !== e.count) begin
					$error("count_out expected %0d actual %0d", e.count, count_out);
					fail_count++;
				end
				if (merged !== e.merged) begin
					$error("merged expected %0d actual %0d", e.merged, merged);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void add_row(logic act, logic [9:0] a, logic [9:0] b, logic typed,
			int unsigned lbl, int unsigned sz, int unsigned cnt, logic mrg);
		stim_row_t row;
		row.act = act;
		row.a = a;
		row.b = b;
		row.typed = typed;
		row.rep.label = lbl[9:0];
		row.rep.size = sz[10:0];
		row.rep.count = cnt[10:0];
		row.rep.merged = mrg;
		directed_rows = {directed_rows, row};
	endfunction

	task automatic random_phase(int items, int gap_pct);
		int unsigned kind;
		int unsigned span;
		logic [9:0] a;
		logic [9:0] b;
		send_gap_pct = gap_pct;
		for (int i = 0; i < items; i++) begin
			kind = $urandom_range(99);
			span = ($urandom_range(9) == 0) ? 1023 : 63;
			a = 10'($urandom_range(span));
			b = 10'($urandom_range(span));
			if (kind < 55)
				send_item(ACT_UNION, a, b, 1'b0, '{default: '0});
			else if (kind < 65)
				send_item(ACT_UNION, a, a, 1'b0, '{default: '0});
			else
				send_item(ACT_QUERY, a, 10'($urandom), 1'b0, '{default: '0});
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = 1'b0;
		node_a = '0;
		node_b = '0;
		fail_count = 0;
		idle_cycles = 0;
		send_gap_pct = 0;
		clear_clusters();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		add_row(ACT_QUERY, 10'd0, 10'd1023, 1'b1, 0, 1, 1024, 1'b0);
		add_row(ACT_QUERY, 10'd1023, 10'd0, 1'b1, 1023, 1, 1024, 1'b0);
		add_row(ACT_UNION, 10'd5, 10'd5, 1'b1, 5, 1, 1024, 1'b0);
		add_row(ACT_UNION, 10'd0, 10'd1023, 1'b1, 0, 2, 1023, 1'b1);
		add_row(ACT_UNION, 10'd1023, 10'd0, 1'b1, 0, 2, 1023, 1'b0);
		add_row(ACT_UNION, 10'd1, 10'd1023, 1'b1, 0, 3, 1022, 1'b1);
		add_row(ACT_UNION, 10'd2, 10'd3, 1'b1, 2, 2, 1021, 1'b1);
		add_row(ACT_UNION, 10'd3, 10'd0, 1'b0, 0, 0, 0, 1'b0);
		add_row(ACT_QUERY, 10'd2, 10'd0, 1'b0, 0, 0, 0, 1'b0);
		add_row(ACT_UNION, 10'd682, 10'd341, 1'b0, 0, 0, 0, 1'b0);
		add_row(ACT_UNION, 10'd341, 10'd1, 1'b0, 0, 0, 0, 1'b0);
		add_row(ACT_QUERY, 10'd1023, 10'd1023, 1'b0, 0, 0, 0, 1'b0);
		add_row(ACT_QUERY, 10'd512, 10'd511, 1'b0, 0, 0, 0, 1'b0);
		add_row(ACT_UNION, 10'd512, 10'd511, 1'b0, 0, 0, 0, 1'b0);
		add_row(ACT_UNION, 10'd511, 10'd3, 1'b0, 0, 0, 0, 1'b0);
		add_row(ACT_QUERY, 10'd511, 10'd0, 1'b0, 0, 0, 0, 1'b0);
		foreach (directed_rows[i])
			send_item(directed_rows[i].act, directed_rows[i].a, directed_rows[i].b,
				directed_rows[i].typed, directed_rows[i].rep);

		random_phase(220, 22);
		random_phase(210, 72);
		random_phase(200, 0);

		// Unions over the whole node range grow large clusters and long relabel walks.
		for (int i = 0; i < 200; i++)
			send_item(ACT_UNION, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
				1'b0, '{default: '0});
		send_item(ACT_QUERY, 10'd0, 10'd0, 1'b0, '{default: '0});
		start <= 1'b0;

		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

>>> union_find_member_lists_top.f
hdl/ufml_pkg.sv
hdl/ufml_datapath.sv
hdl/ufml_ctrl.sv
hdl/union_find_member_lists_top.sv
hdl/ufml_checker.sv
verif/tb_union_find_member_lists_top.sv
